### design/ddgc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddgc_pkg
// Shared types, constants and helper functions of the go-to-goal controller.
// ----------------------------------------------------------------------------
package ddgc_pkg;

    localparam int ANG_W   = 28;
    localparam int VEC_W   = 44;
    localparam int COS_W   = 34;
    localparam int SQ_W    = 34;
    localparam int SQ_ITERS = 17;
    localparam int D_W     = 17;
    localparam int ATAN_ENTRIES = 24;

    localparam logic [31:0] ANG_PI      = 32'd52707179;
    localparam logic [31:0] ANG_TWO_PI  = 32'd105414357;
    localparam logic [31:0] ANG_HALF_PI = 32'd26353589;
    localparam logic [31:0] COS_KINV    = 32'd652032874;

    typedef enum logic [1:0] {
        MODE_STOPPED = 2'd0,
        MODE_TURNING = 2'd1,
        MODE_DRIVING = 2'd2
    } drive_mode_t;

    typedef enum logic [2:0] {
        REG_TURN_GAIN         = 3'd0,
        REG_SPEED_GAIN        = 3'd1,
        REG_TURN_LIMIT        = 3'd2,
        REG_SPEED_LIMIT       = 3'd3,
        REG_ARRIVE_TOLERANCE  = 3'd4,
        REG_HEADING_THRESHOLD = 3'd5,
        REG_ROBOT_RADIUS      = 3'd6
    } cfg_reg_t;

    function automatic logic [ANG_W-1:0] atan_entry(input int idx);
        logic [ANG_W-1:0] val;
        case (idx)
            0:  val = ANG_W'(13176795);
            1:  val = ANG_W'(7778716);
            2:  val = ANG_W'(4110060);
            3:  val = ANG_W'(2086331);
            4:  val = ANG_W'(1047214);
            5:  val = ANG_W'(524117);
            6:  val = ANG_W'(262123);
            7:  val = ANG_W'(131069);
            8:  val = ANG_W'(65536);
            9:  val = ANG_W'(32768);
            10: val = ANG_W'(16384);
            11: val = ANG_W'(8192);
            12: val = ANG_W'(4096);
            13: val = ANG_W'(2048);
            14: val = ANG_W'(1024);
            15: val = ANG_W'(512);
            16: val = ANG_W'(256);
            17: val = ANG_W'(128);
            18: val = ANG_W'(64);
            19: val = ANG_W'(32);
            20: val = ANG_W'(16);
            21: val = ANG_W'(8);
            22: val = ANG_W'(4);
            23: val = ANG_W'(2);
            default: val = '0;
        endcase
        return val;
    endfunction

    function automatic logic [15:0] sat16(input logic signed [22:0] v);
        logic [15:0] res;
        if (v > 23'sd32767)
        begin
            res = 16'h7fff;
        end
        else if (v < -23'sd32768)
        begin
            res = 16'h8000;
        end
        else
        begin
            res = v[15:0];
        end
        return res;
    endfunction

endpackage

### design/ddgc_cordic_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddgc_cordic_stage
// One registered CORDIC micro-rotation, in vectoring or rotation mode.
// ----------------------------------------------------------------------------
module ddgc_cordic_stage #(
    parameter int DATA_W    = 44,
    parameter int ANGLE_W   = 28,
    parameter int SHIFT     = 0,
    parameter bit VECTORING = 1'b1
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [DATA_W-1:0]  x_in,
    input  logic signed [DATA_W-1:0]  y_in,
    input  logic signed [ANGLE_W-1:0] z_in,
    input  logic        [ANGLE_W-1:0] angle,
    output logic signed [DATA_W-1:0]  x_out,
    output logic signed [DATA_W-1:0]  y_out,
    output logic signed [ANGLE_W-1:0] z_out
);

    logic signed [DATA_W-1:0]  xs;
    logic signed [DATA_W-1:0]  ys;
    logic                      pos;
    logic signed [DATA_W-1:0]  x_next;
    logic signed [DATA_W-1:0]  y_next;
    logic signed [ANGLE_W-1:0] z_next;
    logic signed [DATA_W-1:0]  x_reg;
    logic signed [DATA_W-1:0]  y_reg;
    logic signed [ANGLE_W-1:0] z_reg;

    always_comb
    begin
        xs  = x_in >>> SHIFT;
        ys  = y_in >>> SHIFT;
        pos = VECTORING ? (y_in <= 0) : (z_in >= 0);
        if (pos)
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - $signed(angle);
        end
        else
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + $signed(angle);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

### design/diff_drive_goto_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diff_drive_goto_controller_top
// Go-to-goal controller for a differential-drive robot: pose and target in,
// wheel speeds and drive mode out.
// ----------------------------------------------------------------------------
// A new request is taken in every clock cycle unless a finished result is
// stalled at the output. Each request passes through the offset and square
// stages, the square-root and arc-tangent pipeline, the angle wrap, the
// cosine CORDIC pipeline and the speed multipliers. The whole pipeline holds
// while a finished result waits to be taken.
module diff_drive_goto_controller_top #(
    parameter int CORDIC_STEPS = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // goal_x, goal_y, robot_x, robot_y, robot_heading
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // left_speed, right_speed, drive_mode, zero fill
    output logic [39:0] m_axis_tdata,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    import ddgc_pkg::*;

    localparam int L1 = (CORDIC_STEPS > SQ_ITERS) ? CORDIC_STEPS : SQ_ITERS;

    logic [15:0] turn_gain_reg, speed_gain_reg, turn_limit_reg, speed_limit_reg;
    logic [15:0] arrive_tol_reg, heading_thr_reg, robot_radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_gain_reg    <= 16'd1638;
            speed_gain_reg   <= 16'd8192;
            turn_limit_reg   <= 16'd2048;
            speed_limit_reg  <= 16'd5120;
            arrive_tol_reg   <= 16'd205;
            heading_thr_reg  <= 16'd410;
            robot_radius_reg <= 16'd287;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_TURN_GAIN:         turn_gain_reg    <= cfg_wdata;
                REG_SPEED_GAIN:        speed_gain_reg   <= cfg_wdata;
                REG_TURN_LIMIT:        turn_limit_reg   <= cfg_wdata;
                REG_SPEED_LIMIT:       speed_limit_reg  <= cfg_wdata;
                REG_ARRIVE_TOLERANCE:  arrive_tol_reg   <= cfg_wdata;
                REG_HEADING_THRESHOLD: heading_thr_reg  <= cfg_wdata;
                REG_ROBOT_RADIUS:      robot_radius_reg <= cfg_wdata;
                default:               ;
            endcase
        end
    end

    logic en;
    logic f4_valid_reg;

    assign en            = !f4_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    // Stage A: offsets to the target.
    logic                a_valid_reg;
    logic signed [16:0]  a_dx_reg, a_dy_reg;
    logic signed [15:0]  a_head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_dx_reg   <= $signed({s_axis_tdata[15], s_axis_tdata[15:0]})
                        - $signed({s_axis_tdata[47], s_axis_tdata[47:32]});
            a_dy_reg   <= $signed({s_axis_tdata[31], s_axis_tdata[31:16]})
                        - $signed({s_axis_tdata[63], s_axis_tdata[63:48]});
            a_head_reg <= $signed(s_axis_tdata[79:64]);
        end
    end

    // Stage B: squares and the half-plane pre-rotation of the bearing vector.
    logic                    b_valid_reg;
    logic signed [33:0]      b_dx2_reg, b_dy2_reg;
    logic signed [VEC_W-1:0] b_x_reg, b_y_reg;
    logic signed [ANG_W-1:0] b_z_reg;
    logic signed [15:0]      b_head_reg;
    logic signed [VEC_W-1:0] dx_ext, dy_ext;

    always_comb
    begin
        dx_ext = VEC_W'(a_dx_reg) <<< 24;
        dy_ext = VEC_W'(a_dy_reg) <<< 24;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_dx2_reg  <= a_dx_reg * a_dx_reg;
            b_dy2_reg  <= a_dy_reg * a_dy_reg;
            b_head_reg <= a_head_reg;
            if (a_dx_reg < 0)
            begin
                b_x_reg <= -dx_ext;
                b_y_reg <= -dy_ext;
                b_z_reg <= (a_dy_reg >= 0) ? $signed(ANG_W'(ANG_PI))
                                           : -$signed(ANG_W'(ANG_PI));
            end
            else
            begin
                b_x_reg <= dx_ext;
                b_y_reg <= dy_ext;
                b_z_reg <= '0;
            end
        end
    end

    // Square root and arc tangent, at most one iteration of each per stage.
    logic                    sv_valid_reg [0:L1];
    logic [SQ_W-1:0]         sq_n_reg     [0:L1];
    logic [SQ_W-1:0]         sq_root_reg  [0:L1];
    logic signed [VEC_W-1:0] ax_reg       [0:L1];
    logic signed [VEC_W-1:0] ay_reg       [0:L1];
    logic signed [ANG_W-1:0] az_reg       [0:L1];
    logic signed [15:0]      sv_head_reg  [0:L1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            sv_valid_reg[0] <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_n_reg[0]    <= SQ_W'(b_dx2_reg) + SQ_W'(b_dy2_reg);
            sq_root_reg[0] <= '0;
            ax_reg[0]      <= b_x_reg;
            ay_reg[0]      <= b_y_reg;
            az_reg[0]      <= b_z_reg;
            sv_head_reg[0] <= b_head_reg;
        end
    end

    for (genvar k = 0; k < L1; k++)
    begin : g_vec
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv_valid_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                sv_valid_reg[k+1] <= sv_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sv_head_reg[k+1] <= sv_head_reg[k];
            end
        end

        if (k < SQ_ITERS)
        begin : g_sqrt
            localparam logic [SQ_W-1:0] SQ_BIT = SQ_W'(1) << (2 * (SQ_ITERS - 1 - k));
            logic [SQ_W-1:0] trial;

            assign trial = sq_root_reg[k] + SQ_BIT;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (sq_n_reg[k] >= trial)
                    begin
                        sq_n_reg[k+1]    <= sq_n_reg[k] - trial;
                        sq_root_reg[k+1] <= (sq_root_reg[k] >> 1) + SQ_BIT;
                    end
                    else
                    begin
                        sq_n_reg[k+1]    <= sq_n_reg[k];
                        sq_root_reg[k+1] <= sq_root_reg[k] >> 1;
                    end
                end
            end
        end
        else
        begin : g_sqrt_pass
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sq_n_reg[k+1]    <= sq_n_reg[k];
                    sq_root_reg[k+1] <= sq_root_reg[k];
                end
            end
        end

        if (k < CORDIC_STEPS)
        begin : g_atan
            ddgc_cordic_stage #(
                .DATA_W    (VEC_W),
                .ANGLE_W   (ANG_W),
                .SHIFT     (k),
                .VECTORING (1'b1)
            ) u_stage (
                .clk   (clk),
                .en    (en),
                .x_in  (ax_reg[k]),
                .y_in  (ay_reg[k]),
                .z_in  (az_reg[k]),
                .angle (atan_entry(k)),
                .x_out (ax_reg[k+1]),
                .y_out (ay_reg[k+1]),
                .z_out (az_reg[k+1])
            );
        end
        else
        begin : g_atan_pass
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    ax_reg[k+1] <= ax_reg[k];
                    ay_reg[k+1] <= ay_reg[k];
                    az_reg[k+1] <= az_reg[k];
                end
            end
        end
    end

    // Heading error wrap: shift into positive range, then restoring reduction.
    localparam logic [29:0] WRAP4 = 30'(4 * ANG_TWO_PI);
    localparam logic [29:0] WRAP2 = 30'(2 * ANG_TWO_PI);
    localparam logic [29:0] WRAP1 = 30'(ANG_TWO_PI);

    logic              e1_valid_reg, e2_valid_reg, e3_valid_reg, e4_valid_reg;
    logic              e5_valid_reg, e6_valid_reg;
    logic [29:0]       e1_u_reg, e2_u_reg, e3_u_reg, e4_u_reg;
    logic [D_W-1:0]    e1_d_reg, e2_d_reg, e3_d_reg, e4_d_reg, e5_d_reg, e6_d_reg;
    logic [31:0]       u_wide;

    assign u_wide = 32'(az_reg[L1]) - {{4{sv_head_reg[L1][15]}}, sv_head_reg[L1], 12'b0}
                  + ANG_PI + 32'(4 * ANG_TWO_PI);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_valid_reg <= 1'b0;
            e2_valid_reg <= 1'b0;
            e3_valid_reg <= 1'b0;
            e4_valid_reg <= 1'b0;
            e5_valid_reg <= 1'b0;
            e6_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            e1_valid_reg <= sv_valid_reg[L1];
            e2_valid_reg <= e1_valid_reg;
            e3_valid_reg <= e2_valid_reg;
            e4_valid_reg <= e3_valid_reg;
            e5_valid_reg <= e4_valid_reg;
            e6_valid_reg <= e5_valid_reg;
        end
    end

    logic signed [ANG_W-1:0] e5_err_reg;
    logic [25:0]             e5_mag_reg;
    drive_mode_t             e5_mode_reg, e6_mode_reg;
    logic signed [ANG_W-1:0] err_val;
    logic [25:0]             err_mag;
    logic [41:0]             e6_wprod_reg;
    logic                    e6_wneg_reg;
    logic signed [ANG_W-1:0] e6_z_reg;
    logic                    e6_flip_reg;

    assign err_val = $signed({1'b0, e4_u_reg[26:0]}) - $signed(ANG_W'(ANG_PI));
    assign err_mag = err_val[ANG_W-1] ? 26'(-err_val) : 26'(err_val);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_u_reg <= u_wide[29:0];
            e1_d_reg <= sq_root_reg[L1][D_W-1:0];
            e2_u_reg <= (e1_u_reg >= WRAP4) ? e1_u_reg - WRAP4 : e1_u_reg;
            e2_d_reg <= e1_d_reg;
            e3_u_reg <= (e2_u_reg >= WRAP2) ? e2_u_reg - WRAP2 : e2_u_reg;
            e3_d_reg <= e2_d_reg;
            e4_u_reg <= (e3_u_reg >= WRAP1) ? e3_u_reg - WRAP1 : e3_u_reg;
            e4_d_reg <= e3_d_reg;

            e5_err_reg <= err_val;
            e5_mag_reg <= err_mag;
            e5_d_reg   <= e4_d_reg;
            if (e4_d_reg <= D_W'(arrive_tol_reg))
            begin
                e5_mode_reg <= MODE_STOPPED;
            end
            else if (28'(err_mag) > {heading_thr_reg, 12'b0})
            begin
                e5_mode_reg <= MODE_TURNING;
            end
            else
            begin
                e5_mode_reg <= MODE_DRIVING;
            end

            e6_wprod_reg <= turn_gain_reg * e5_mag_reg;
            e6_wneg_reg  <= e5_err_reg < 0;
            e6_d_reg     <= e5_d_reg;
            e6_mode_reg  <= e5_mode_reg;
            if (e5_err_reg > $signed(ANG_W'(ANG_HALF_PI)))
            begin
                e6_z_reg    <= e5_err_reg - $signed(ANG_W'(ANG_PI));
                e6_flip_reg <= 1'b1;
            end
            else if (e5_err_reg < -$signed(ANG_W'(ANG_HALF_PI)))
            begin
                e6_z_reg    <= e5_err_reg + $signed(ANG_W'(ANG_PI));
                e6_flip_reg <= 1'b1;
            end
            else
            begin
                e6_z_reg    <= e5_err_reg;
                e6_flip_reg <= 1'b0;
            end
        end
    end

    // Cosine pipeline; index 0 also limits the angular command.
    logic                    cv_valid_reg [0:CORDIC_STEPS];
    logic signed [COS_W-1:0] cx_reg       [0:CORDIC_STEPS];
    logic signed [COS_W-1:0] cy_reg       [0:CORDIC_STEPS];
    logic signed [ANG_W-1:0] cz_reg       [0:CORDIC_STEPS];
    logic [15:0]             cw_mag_reg   [0:CORDIC_STEPS];
    logic                    cw_neg_reg   [0:CORDIC_STEPS];
    logic [D_W-1:0]          cd_reg       [0:CORDIC_STEPS];
    drive_mode_t             cmode_reg    [0:CORDIC_STEPS];
    logic                    cflip_reg    [0:CORDIC_STEPS];
    logic [18:0]             w_round;

    assign w_round = 19'((e6_wprod_reg + 42'(1 << 23)) >> 24);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            cv_valid_reg[0] <= e6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg[0]     <= COS_W'(COS_KINV);
            cy_reg[0]     <= '0;
            cz_reg[0]     <= e6_z_reg;
            cw_mag_reg[0] <= (w_round > 19'(turn_limit_reg)) ? turn_limit_reg : w_round[15:0];
            cw_neg_reg[0] <= e6_wneg_reg;
            cd_reg[0]     <= e6_d_reg;
            cmode_reg[0]  <= e6_mode_reg;
            cflip_reg[0]  <= e6_flip_reg;
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cos
        ddgc_cordic_stage #(
            .DATA_W    (COS_W),
            .ANGLE_W   (ANG_W),
            .SHIFT     (k),
            .VECTORING (1'b0)
        ) u_stage (
            .clk   (clk),
            .en    (en),
            .x_in  (cx_reg[k]),
            .y_in  (cy_reg[k]),
            .z_in  (cz_reg[k]),
            .angle (atan_entry(k)),
            .x_out (cx_reg[k+1]),
            .y_out (cy_reg[k+1]),
            .z_out (cz_reg[k+1])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cv_valid_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                cv_valid_reg[k+1] <= cv_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cw_mag_reg[k+1] <= cw_mag_reg[k];
                cw_neg_reg[k+1] <= cw_neg_reg[k];
                cd_reg[k+1]     <= cd_reg[k];
                cmode_reg[k+1]  <= cmode_reg[k];
                cflip_reg[k+1]  <= cflip_reg[k];
            end
        end
    end

    // Speed commands and wheel mixing.
    localparam int CS = CORDIC_STEPS;

    logic signed [COS_W-1:0] cos_val;
    logic [COS_W-1:0]        cos_mag;
    logic [31:0]             rw_prod;

    assign cos_val = cflip_reg[CS] ? -cx_reg[CS] : cx_reg[CS];
    assign cos_mag = cos_val[COS_W-1] ? COS_W'(-cos_val) : COS_W'(cos_val);
    assign rw_prod = robot_radius_reg * cw_mag_reg[CS];

    logic              f1_valid_reg, f2_valid_reg, f3_valid_reg;
    logic [20:0]       f1_c20_reg;
    logic              f1_cneg_reg, f2_cneg_reg, f3_cneg_reg;
    logic [32:0]       f1_p1_reg;
    logic [20:0]       f1_rw_reg, f2_rw_reg, f3_rw_reg;
    logic [15:0]       f1_w_reg, f2_w_reg, f3_w_reg;
    logic              f1_wneg_reg, f2_wneg_reg, f3_wneg_reg;
    drive_mode_t       f1_mode_reg, f2_mode_reg, f3_mode_reg, f4_mode_reg;
    logic [53:0]       f2_vprod_reg;
    logic [15:0]       f3_v_reg;
    logic [21:0]       v_round;
    logic [15:0]       f4_left_reg, f4_right_reg;

    assign v_round = 22'((f2_vprod_reg + 54'(64'd1 << 31)) >> 32);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
            f4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_valid_reg <= cv_valid_reg[CS];
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
            f4_valid_reg <= f3_valid_reg;
        end
    end

    logic signed [16:0] v_s;
    logic signed [21:0] rw_s;
    logic signed [16:0] w_s;
    logic signed [22:0] left_raw, right_raw;

    always_comb
    begin
        v_s  = f3_cneg_reg ? -$signed({1'b0, f3_v_reg}) : $signed({1'b0, f3_v_reg});
        rw_s = f3_wneg_reg ? -$signed({1'b0, f3_rw_reg}) : $signed({1'b0, f3_rw_reg});
        w_s  = f3_wneg_reg ? -$signed({1'b0, f3_w_reg}) : $signed({1'b0, f3_w_reg});
        case (f3_mode_reg)
            MODE_TURNING:
            begin
                left_raw  = -23'(w_s);
                right_raw = 23'(w_s);
            end
            MODE_DRIVING:
            begin
                left_raw  = 23'(v_s) - 23'(rw_s);
                right_raw = 23'(v_s) + 23'(rw_s);
            end
            default:
            begin
                left_raw  = '0;
                right_raw = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_c20_reg  <= 21'((cos_mag + COS_W'(512)) >> 10);
            f1_cneg_reg <= cos_val[COS_W-1];
            f1_p1_reg   <= speed_gain_reg * cd_reg[CS];
            f1_rw_reg   <= 21'((33'(rw_prod) + 33'd2048) >> 12);
            f1_w_reg    <= cw_mag_reg[CS];
            f1_wneg_reg <= cw_neg_reg[CS];
            f1_mode_reg <= cmode_reg[CS];

            f2_vprod_reg <= f1_p1_reg * f1_c20_reg;
            f2_cneg_reg  <= f1_cneg_reg;
            f2_rw_reg    <= f1_rw_reg;
            f2_w_reg     <= f1_w_reg;
            f2_wneg_reg  <= f1_wneg_reg;
            f2_mode_reg  <= f1_mode_reg;

            f3_v_reg    <= (v_round > 22'(speed_limit_reg)) ? speed_limit_reg
                                                            : v_round[15:0];
            f3_cneg_reg <= f2_cneg_reg;
            f3_rw_reg   <= f2_rw_reg;
            f3_w_reg    <= f2_w_reg;
            f3_wneg_reg <= f2_wneg_reg;
            f3_mode_reg <= f2_mode_reg;

            f4_left_reg  <= sat16(left_raw);
            f4_right_reg <= sat16(right_raw);
            f4_mode_reg  <= f3_mode_reg;
        end
    end

    assign m_axis_tvalid = f4_valid_reg;
    assign m_axis_tdata  = {6'b0, f4_mode_reg, f4_right_reg, f4_left_reg};

`ifndef ASSERT_OFF
    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow the output stage");

    a_stopped_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[33:32] == MODE_STOPPED)
        |-> (m_axis_tdata[31:0] == 32'd0))
        else $error("stopped result carries a non-zero wheel speed");

    a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");
`endif

endmodule
